/* hdl/ictf_pkg.sv */
package ictf_pkg;

	localparam int ADDR_W = 3;
	localparam logic REG_BLEND = 1'b0;
	localparam logic REG_SCALE = 1'b1;

	localparam logic [16:0] BLEND_RESET = 17'd64225;
	localparam logic [16:0] FRAC_ONE    = 17'd65536;
	localparam logic [23:0] SCALE_RESET = 24'd256141;
	localparam logic [19:0] MAX_ELAPSED = 20'd1000000;
	localparam logic [27:0] US_DIV      = 28'd256000000;
	localparam logic [59:0] US_HALF     = 60'd128000000;

	localparam int VEC_SHIFT = 14;
	localparam int VEC_W     = 31;
	localparam int CORD_W    = 34;
	localparam int ANG_W     = 27;
	localparam int ROOT_W    = 30;
	localparam int DELTA_W   = 33;
	localparam int PRED_W    = 34;

	localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;

	typedef enum logic [3:0] {
		S_IDLE, S_SQRT, S_ROLL, S_PITCH, S_GX, S_GY, S_GZ, S_BLR, S_BLP, S_UPD
	} ctl_state_t;

	typedef enum logic [1:0] {G_IDLE, G_MUL1, G_MUL2, G_DIV} gyro_phase_t;

	typedef enum logic [1:0] {B_IDLE, B_WGT, B_CMP} blend_phase_t;

	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			5'd0:  r = 27'sd2949120;
			5'd1:  r = 27'sd1740967;
			5'd2:  r = 27'sd919879;
			5'd3:  r = 27'sd466945;
			5'd4:  r = 27'sd234379;
			5'd5:  r = 27'sd117304;
			5'd6:  r = 27'sd58666;
			5'd7:  r = 27'sd29335;
			5'd8:  r = 27'sd14668;
			5'd9:  r = 27'sd7334;
			5'd10: r = 27'sd3667;
			5'd11: r = 27'sd1833;
			5'd12: r = 27'sd917;
			5'd13: r = 27'sd458;
			5'd14: r = 27'sd229;
			5'd15: r = 27'sd115;
			5'd16: r = 27'sd57;
			5'd17: r = 27'sd29;
			5'd18: r = 27'sd14;
			5'd19: r = 27'sd7;
			5'd20: r = 27'sd4;
			5'd21: r = 27'sd2;
			5'd22: r = 27'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sd2147483647;
		lo = -36'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFFFFFF;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

/* hdl/ictf_isqrt.sv */
module ictf_isqrt import ictf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] az,
	output logic               done,
	output logic [ROOT_W-1:0]  root
);

	logic               load_q, run_q, done_q;
	logic [31:0]        sq_q;
	logic [59:0]        n_q, res_q, bit_q;
	logic signed [15:0] mul_op;
	logic signed [31:0] prod;
	logic [31:0]        sum_sq;
	logic [59:0]        trial;

	assign mul_op = load_q ? az : ax;
	assign prod   = mul_op * mul_op;
	assign sum_sq = sq_q + 32'(prod);
	assign trial  = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			load_q <= start;
			if (load_q) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sq_q <= 32'(prod);
		end
		if (load_q) begin
			n_q   <= {sum_sq, 28'b0};
			res_q <= '0;
			bit_q <= 60'(1) << 58;
		end else if (run_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

/* hdl/ictf_cordic.sv */
module ictf_cordic import ictf_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VEC_W-1:0] y_in,
	input  logic signed [VEC_W-1:0] x_in,
	output logic                    done,
	output logic signed [ANG_W-1:0] angle
);

	localparam int IT_W = $clog2(CORDIC_STEPS);
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

	logic                     run_q, done_q;
	logic [IT_W-1:0]          it_q;
	logic signed [CORD_W-1:0] x_q, y_q, dx, dy, x_ext, y_ext;
	logic signed [ANG_W-1:0]  z_q, rot;
	logic                     zero_vec;

	assign x_ext    = CORD_W'(x_in);
	assign y_ext    = CORD_W'(y_in);
	assign zero_vec = (x_in == '0) && (y_in == '0);
	assign dx       = y_q >>> it_q;
	assign dy       = x_q >>> it_q;
	assign rot      = atan_q16(5'(it_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= !zero_vec;
				done_q <= zero_vec;
			end else if (run_q && it_q == IT_LAST) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			it_q <= '0;
			if (zero_vec) begin
				z_q <= '0;
			end else if (x_in < 0) begin
				x_q <= -x_ext;
				y_q <= -y_ext;
				z_q <= (y_in >= 0) ? DEG180 : -DEG180;
			end else begin
				x_q <= x_ext;
				y_q <= y_ext;
				z_q <= '0;
			end
		end else if (run_q) begin
			it_q <= it_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + rot;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - rot;
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

/* hdl/ictf_gyro.sv */
module ictf_gyro import ictf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [15:0]        rate,
	input  logic [23:0]               scale,
	input  logic [19:0]               us,
	output logic                      done,
	output logic signed [DELTA_W-1:0] delta
);

	gyro_phase_t               phase_q, phase_d;
	logic                      done_q, neg_q;
	logic [4:0]                cnt_q;
	logic [59:0]               mcand_q, acc_q, acc_n, sum;
	logic [19:0]               mplier_q;
	logic [27:0]               rem_q, rem_n;
	logic [31:0]               dvd_q, quo_q, quo_n;
	logic [28:0]               trial;
	logic                      ge;
	logic signed [16:0]        rate_ext;
	logic [15:0]               rate_mag;
	logic signed [DELTA_W-1:0] q_ext;

	assign rate_ext = 17'(rate);
	assign rate_mag = 16'(rate < 0 ? -rate_ext : rate_ext);
	assign acc_n    = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign sum      = acc_n + US_HALF;
	assign trial    = {rem_q, dvd_q[31]};
	assign ge       = trial >= {1'b0, US_DIV};
	assign rem_n    = ge ? 28'(trial - {1'b0, US_DIV}) : trial[27:0];
	assign quo_n    = {quo_q[30:0], ge};
	assign q_ext    = $signed({1'b0, quo_n});

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			G_IDLE: if (start) begin
				phase_d = G_MUL1;
			end
			G_MUL1: if (cnt_q == 5'd15) begin
				phase_d = G_MUL2;
			end
			G_MUL2: if (cnt_q == 5'd19) begin
				phase_d = G_DIV;
			end
			G_DIV: if (cnt_q == 5'd31) begin
				phase_d = G_IDLE;
			end
			default: phase_d = G_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == G_DIV) && (phase_d == G_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			G_IDLE: begin
				neg_q    <= rate < 0;
				mcand_q  <= 60'(scale);
				mplier_q <= 20'(rate_mag);
				acc_q    <= '0;
				cnt_q    <= '0;
			end
			G_MUL1: begin
				if (phase_d == G_MUL2) begin
					mcand_q  <= acc_n;
					mplier_q <= us;
					acc_q    <= '0;
					cnt_q    <= '0;
				end else begin
					acc_q    <= acc_n;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
				end
			end
			G_MUL2: begin
				acc_q    <= acc_n;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				if (phase_d == G_DIV) begin
					rem_q <= sum[59:32];
					dvd_q <= sum[31:0];
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			G_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= rem_n;
				dvd_q <= dvd_q << 1;
				quo_q <= quo_n;
				if (phase_d == G_IDLE) begin
					delta <= neg_q ? -q_ext : q_ext;
				end
			end
			default: cnt_q <= '0;
		endcase
	end

	assign done = done_q;

endmodule

/* hdl/ictf_blend.sv */
module ictf_blend import ictf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [16:0]              w,
	input  logic signed [PRED_W-1:0] pred,
	input  logic signed [ANG_W-1:0]  acc,
	output logic                     done,
	output logic signed [31:0]       angle
);

	blend_phase_t       phase_q, phase_d;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [16:0]        w_clamp, mplier_q, comp_q;
	logic signed [51:0] mcand_q, sum_q, sum_n;
	logic signed [ANG_W-1:0] acc_q;

	assign w_clamp = (w > FRAC_ONE) ? FRAC_ONE : w;
	assign sum_n   = mplier_q[0] ? sum_q + mcand_q : sum_q;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			B_IDLE: if (start) begin
				phase_d = B_WGT;
			end
			B_WGT: if (cnt_q == 5'd16) begin
				phase_d = B_CMP;
			end
			B_CMP: if (cnt_q == 5'd16) begin
				phase_d = B_IDLE;
			end
			default: phase_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == B_CMP) && (phase_d == B_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			B_IDLE: begin
				mplier_q <= w_clamp;
				comp_q   <= FRAC_ONE - w_clamp;
				mcand_q  <= 52'(pred);
				acc_q    <= acc;
				sum_q    <= 52'sd32768;
				cnt_q    <= '0;
			end
			B_WGT: begin
				sum_q <= sum_n;
				if (phase_d == B_CMP) begin
					mplier_q <= comp_q;
					mcand_q  <= 52'(acc_q);
					cnt_q    <= '0;
				end else begin
					mplier_q <= mplier_q >> 1;
					mcand_q  <= mcand_q <<< 1;
					cnt_q    <= cnt_q + 1'b1;
				end
			end
			B_CMP: begin
				sum_q    <= sum_n;
				mplier_q <= mplier_q >> 1;
				mcand_q  <= mcand_q <<< 1;
				cnt_q    <= cnt_q + 1'b1;
				if (phase_d == B_IDLE) begin
					angle <= sat32(sum_n[51:16]);
				end
			end
			default: cnt_q <= '0;
		endcase
	end

	assign done = done_q;

endmodule

/* hdl/imu_complementary_tilt_filter.sv */
// Channel  | Handshake                   | Payload
// sample   | sample_valid / sample_stall | acc_x..z, rate_x..z, elapsed_us
// angle    | angle_valid / angle_stall   | angle_x, angle_y, angle_z
// config   | APB write/read              | blend_weight_q16 @0, gyro_scale_q24 @4
//
// A result is written to the output register in S_UPD; the next sample is taken in
// the cycle after that at the earliest.
// Most of the work is the bit-serial gyro multiply and divide for each axis.
// A sample is taken only when the sequencer is idle; the last result waits in
// the output register while the next sample is worked on.
// A stalled result holds the final update until it is taken.
// Reset clears the angles to zero and loads the register defaults.
module imu_complementary_tilt_filter import ictf_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] acc_x,
	input  logic signed [15:0] acc_y,
	input  logic signed [15:0] acc_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic [19:0]        elapsed_us,
	output logic               angle_valid,
	input  logic               angle_stall,
	output logic signed [31:0] angle_x,
	output logic signed [31:0] angle_y,
	output logic signed [31:0] angle_z
);

	ctl_state_t state_q, state_d;
	logic       go_q, go_d, upd;
	logic       out_valid_q;
	logic [16:0] weight_q;
	logic [23:0] scale_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q, new_roll_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [19:0]        us_q;
	logic signed [ANG_W-1:0]   acc_roll_q, acc_pitch_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q, dz_q;

	logic                      sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]         sqrt_root;
	logic                      cord_start, cord_done;
	logic signed [VEC_W-1:0]   cord_y, cord_x;
	logic signed [ANG_W-1:0]   cord_angle;
	logic                      gyro_start, gyro_done;
	logic signed [15:0]        gyro_rate;
	logic signed [DELTA_W-1:0] gyro_delta;
	logic                      blend_start, blend_done;
	logic signed [PRED_W-1:0]  blend_pred;
	logic signed [ANG_W-1:0]   blend_acc;
	logic signed [31:0]        blend_angle;
	logic signed [16:0]        ay_neg;

	always_comb begin
		state_d = state_q;
		go_d    = 1'b0;
		upd     = 1'b0;
		unique case (state_q)
			S_IDLE: if (sample_valid) begin
				state_d = S_SQRT;
				go_d    = 1'b1;
			end
			S_SQRT: if (sqrt_done) begin
				state_d = S_ROLL;
				go_d    = 1'b1;
			end
			S_ROLL: if (cord_done) begin
				state_d = S_PITCH;
				go_d    = 1'b1;
			end
			S_PITCH: if (cord_done) begin
				state_d = S_GX;
				go_d    = 1'b1;
			end
			S_GX: if (gyro_done) begin
				state_d = S_GY;
				go_d    = 1'b1;
			end
			S_GY: if (gyro_done) begin
				state_d = S_GZ;
				go_d    = 1'b1;
			end
			S_GZ: if (gyro_done) begin
				state_d = S_BLR;
				go_d    = 1'b1;
			end
			S_BLR: if (blend_done) begin
				state_d = S_BLP;
				go_d    = 1'b1;
			end
			S_BLP: if (blend_done) begin
				state_d = S_UPD;
			end
			S_UPD: if (!out_valid_q || !angle_stall) begin
				state_d = S_IDLE;
				upd     = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			weight_q    <= BLEND_RESET;
			scale_q     <= SCALE_RESET;
			roll_q      <= '0;
			pitch_q     <= '0;
			yaw_q       <= '0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
			if (upd) begin
				out_valid_q <= 1'b1;
				roll_q      <= new_roll_q;
				pitch_q     <= blend_angle;
				yaw_q       <= sat32(36'(yaw_q) + 36'(dz_q));
			end else if (out_valid_q && !angle_stall) begin
				out_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					REG_BLEND: weight_q <= pwdata[16:0];
					REG_SCALE: scale_q  <= pwdata[23:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && sample_valid) begin
			ax_q <= acc_x;
			ay_q <= acc_y;
			az_q <= acc_z;
			gx_q <= rate_x;
			gy_q <= rate_y;
			gz_q <= rate_z;
			us_q <= (elapsed_us > MAX_ELAPSED) ? MAX_ELAPSED : elapsed_us;
		end
		if (state_q == S_ROLL && cord_done) begin
			acc_roll_q <= cord_angle;
		end
		if (state_q == S_PITCH && cord_done) begin
			acc_pitch_q <= cord_angle;
		end
		if (gyro_done) begin
			unique case (state_q)
				S_GX:    dx_q <= gyro_delta;
				S_GY:    dy_q <= gyro_delta;
				S_GZ:    dz_q <= gyro_delta;
				default: dz_q <= dz_q;
			endcase
		end
		if (state_q == S_BLR && blend_done) begin
			new_roll_q <= blend_angle;
		end
	end

	assign ay_neg      = -17'(ay_q);
	assign sqrt_start  = go_q && state_q == S_SQRT;
	assign cord_start  = go_q && (state_q == S_ROLL || state_q == S_PITCH);
	assign gyro_start  = go_q && (state_q == S_GX || state_q == S_GY || state_q == S_GZ);
	assign blend_start = go_q && (state_q == S_BLR || state_q == S_BLP);

	always_comb begin
		if (state_q == S_ROLL) begin
			cord_y = VEC_W'($signed({ay_neg, {VEC_SHIFT{1'b0}}}));
			cord_x = $signed({1'b0, sqrt_root});
		end else begin
			cord_y = VEC_W'($signed({ax_q, {VEC_SHIFT{1'b0}}}));
			cord_x = VEC_W'($signed({az_q, {VEC_SHIFT{1'b0}}}));
		end
		case (state_q)
			S_GX:    gyro_rate = gx_q;
			S_GY:    gyro_rate = gy_q;
			default: gyro_rate = gz_q;
		endcase
		if (state_q == S_BLR) begin
			blend_pred = PRED_W'(roll_q) + PRED_W'(dx_q);
			blend_acc  = acc_roll_q;
		end else begin
			blend_pred = PRED_W'(pitch_q) + PRED_W'(dy_q);
			blend_acc  = acc_pitch_q;
		end
	end

	ictf_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.ax     (ax_q),
		.az     (az_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	ictf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.y_in   (cord_y),
		.x_in   (cord_x),
		.done   (cord_done),
		.angle  (cord_angle)
	);

	ictf_gyro u_gyro (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gyro_start),
		.rate   (gyro_rate),
		.scale  (scale_q),
		.us     (us_q),
		.done   (gyro_done),
		.delta  (gyro_delta)
	);

	ictf_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.w      (weight_q),
		.pred   (blend_pred),
		.acc    (blend_acc),
		.done   (blend_done),
		.angle  (blend_angle)
	);

	assign sample_stall = state_q != S_IDLE;
	assign angle_valid  = out_valid_q;
	assign angle_x      = roll_q;
	assign angle_y      = pitch_q;
	assign angle_z      = yaw_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == REG_SCALE) ? {8'b0, scale_q} : {15'b0, weight_q};

endmodule

/* hdl/ictf_checker.sv */
module ictf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               angle_valid,
	input logic               angle_stall,
	input logic signed [31:0] angle_x,
	input logic signed [31:0] angle_y,
	input logic signed [31:0] angle_z
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken while idle did not start work");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(angle_valid) |-> !sample_stall)
		else $error("result appeared while still busy");

	a_angles_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_stall && $past(!sample_stall) && !$rose(angle_valid)
		|-> $stable(angle_x) && $stable(angle_y) && $stable(angle_z))
		else $error("angles changed without an update");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && angle_stall |=> angle_valid && $stable(angle_x)
			&& $stable(angle_y) && $stable(angle_z))
		else $error("stalled result dropped or changed");

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (.*);
